// File: rtl/nrsp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the name record stream parser.
// No dependencies; used by nrsp_core and name_record_stream_parser.
package nrsp_pkg;

    localparam int MAX_ALIAS_BYTES_DEF = 63;
    localparam int HDR_BYTES           = 10;
    localparam int FPRINT_BYTES        = 32;
    localparam int TS_BYTES            = 8;
    localparam int SIG_BYTES           = 64;
    localparam int MIN_RECORD          = 114;
    localparam int MAGIC_BYTES         = 8;
    localparam int VERSION_POS         = 8;
    localparam int ALEN_POS            = 9;
    localparam logic [7:0] REC_VERSION = 8'd1;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    typedef enum logic [2:0] {
        TAG_MAGIC     = 3'd0,
        TAG_VERSION   = 3'd1,
        TAG_ALEN      = 3'd2,
        TAG_ALIAS     = 3'd3,
        TAG_FPRINT    = 3'd4,
        TAG_TSTAMP    = 3'd5,
        TAG_SIG       = 3'd6,
        TAG_TRAIL     = 3'd7
    } t_tag;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_BAD_VER   = 3'd3,
        ST_BAD_ALEN  = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    typedef struct packed {
        t_tag          tag;
        logic [5:0]    offset;
        logic [7:0]    data;
        logic          rec_end;
        t_status       status;
        logic [7:0]    alen;
        logic [63:0]   tstamp;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = 8'h42;
            3'd1:    v = 8'h4C;
            3'd2:    v = 8'h4E;
            3'd3:    v = 8'h4D;
            3'd4:    v = 8'h56;
            3'd5:    v = 8'h30;
            3'd6:    v = 8'h31;
            3'd7:    v = 8'h00;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/nrsp_core.sv
`timescale 1ns / 1ps
// Per-byte field decode, record state and end-of-record status.
// Depends on nrsp_pkg.
module nrsp_core #(
    parameter int MAX_ALIAS_BYTES = nrsp_pkg::MAX_ALIAS_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output nrsp_pkg::t_result  o_result
);

    logic [7:0]  r_byte_count, n_byte_count;
    logic [7:0]  r_alen,       n_alen;
    logic        r_magic_bad,  n_magic_bad;
    logic        r_version_bad, n_version_bad;
    logic [63:0] r_time_accum, n_time_accum;

    logic        w_alias_bad;
    logic [7:0]  w_q_alias, w_q_fp, w_q_ts, w_q_sig;
    logic [8:0]  w_need;

    assign w_alias_bad = (r_byte_count > 8'(nrsp_pkg::ALEN_POS)) &&
                         ((r_alen == 8'd0) || (r_alen > 8'(MAX_ALIAS_BYTES)));
    assign w_q_alias = r_byte_count - 8'(nrsp_pkg::HDR_BYTES);
    assign w_q_fp    = w_q_alias - r_alen;
    assign w_q_ts    = w_q_fp - 8'(nrsp_pkg::FPRINT_BYTES);
    assign w_q_sig   = w_q_ts - 8'(nrsp_pkg::TS_BYTES);

    always_comb begin
        n_byte_count  = r_byte_count;
        n_alen        = r_alen;
        n_magic_bad   = r_magic_bad;
        n_version_bad = r_version_bad;
        n_time_accum  = r_time_accum;
        w_need        = '0;

        o_result           = '0;
        o_result.tag       = nrsp_pkg::TAG_TRAIL;
        o_result.data      = i_byte;
        o_result.status    = nrsp_pkg::ST_OK;

        if (r_magic_bad || r_version_bad || w_alias_bad) begin
            o_result.tag = nrsp_pkg::TAG_TRAIL;
        end else if (r_byte_count < 8'(nrsp_pkg::MAGIC_BYTES)) begin
            o_result.tag    = nrsp_pkg::TAG_MAGIC;
            o_result.offset = r_byte_count[5:0];
            if (i_byte != nrsp_pkg::magic_byte(r_byte_count[2:0])) begin
                n_magic_bad = 1'b1;
            end
        end else if (r_byte_count == 8'(nrsp_pkg::VERSION_POS)) begin
            o_result.tag = nrsp_pkg::TAG_VERSION;
            if (i_byte != nrsp_pkg::REC_VERSION) begin
                n_version_bad = 1'b1;
            end
        end else if (r_byte_count == 8'(nrsp_pkg::ALEN_POS)) begin
            o_result.tag = nrsp_pkg::TAG_ALEN;
            n_alen       = i_byte;
        end else if (w_q_alias < r_alen) begin
            o_result.tag    = nrsp_pkg::TAG_ALIAS;
            o_result.offset = w_q_alias[5:0];
        end else if (w_q_fp < 8'(nrsp_pkg::FPRINT_BYTES)) begin
            o_result.tag    = nrsp_pkg::TAG_FPRINT;
            o_result.offset = w_q_fp[5:0];
        end else if (w_q_ts < 8'(nrsp_pkg::TS_BYTES)) begin
            o_result.tag    = nrsp_pkg::TAG_TSTAMP;
            o_result.offset = w_q_ts[5:0];
            for (int k = 0; k < 8; k++) begin
                if (w_q_ts[2:0] == 3'(k)) begin
                    n_time_accum[8*k +: 8] = r_time_accum[8*k +: 8] | i_byte;
                end
            end
        end else if (w_q_sig < 8'(nrsp_pkg::SIG_BYTES)) begin
            o_result.tag    = nrsp_pkg::TAG_SIG;
            o_result.offset = w_q_sig[5:0];
        end

        n_byte_count = (r_byte_count == nrsp_pkg::COUNT_MAX) ? nrsp_pkg::COUNT_MAX
                                                              : r_byte_count + 8'd1;

        if (i_last) begin
            w_need = {1'b0, n_alen} + 9'(nrsp_pkg::HDR_BYTES + nrsp_pkg::FPRINT_BYTES
                                         + nrsp_pkg::TS_BYTES + nrsp_pkg::SIG_BYTES);
            o_result.rec_end = 1'b1;
            o_result.alen    = n_alen;
            if (n_byte_count < 8'(nrsp_pkg::MIN_RECORD)) begin
                o_result.status = nrsp_pkg::ST_SHORT;
            end else if (n_magic_bad) begin
                o_result.status = nrsp_pkg::ST_BAD_MAGIC;
            end else if (n_version_bad) begin
                o_result.status = nrsp_pkg::ST_BAD_VER;
            end else if ((n_alen == 8'd0) || (n_alen > 8'(MAX_ALIAS_BYTES))) begin
                o_result.status = nrsp_pkg::ST_BAD_ALEN;
            end else if ({1'b0, n_byte_count} < w_need) begin
                o_result.status = nrsp_pkg::ST_TRUNC;
            end else begin
                o_result.status = nrsp_pkg::ST_OK;
                o_result.tstamp = n_time_accum;
            end
            n_byte_count  = '0;
            n_alen        = '0;
            n_magic_bad   = 1'b0;
            n_version_bad = 1'b0;
            n_time_accum  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_alen        <= '0;
            r_magic_bad   <= 1'b0;
            r_version_bad <= 1'b0;
            r_time_accum  <= '0;
        end else if (i_fire) begin
            r_byte_count  <= n_byte_count;
            r_alen        <= n_alen;
            r_magic_bad   <= n_magic_bad;
            r_version_bad <= n_version_bad;
            r_time_accum  <= n_time_accum;
        end
    end

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> r_byte_count == 8'd0 && r_alen == 8'd0
                             && !r_magic_bad && !r_version_bad && r_time_accum == 64'd0)
        else $error("record state not cleared after last byte");

    a_count_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_last && r_byte_count == nrsp_pkg::COUNT_MAX
        |=> r_byte_count == nrsp_pkg::COUNT_MAX)
        else $error("byte count left saturation");

endmodule

// File: rtl/name_record_stream_parser.sv
`timescale 1ns / 1ps
// Top level: input register, field decode core and output register.
// Depends on nrsp_pkg and nrsp_core.
//
// Takes a signed name record one byte per request on the slave side (tlast on
// the final byte) and returns one request per byte on the master side, tagged
// with its field and offset; the request carrying tlast also holds the parse
// status, alias length byte and, when the status is ok, the timestamp. One
// byte per clock is sustained while the master side takes every result; a
// byte is held in the input register once it is accepted and its result is
// then held in the result register until the master side takes it. The
// decode of each byte needs the record state left by the one before, which
// is one short compare-and-subtract chain between the two registers.
module name_record_stream_parser #(
    parameter int MAX_ALIAS_BYTES = nrsp_pkg::MAX_ALIAS_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rec_byte
    input  logic        i_s_axis_tlast,   // last_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [95:0] o_m_axis_tdata,   // [5:0] field_offset, [13:6] data_byte,
                                          // [16:14] parse_status, [24:17] alias_length,
                                          // [88:25] timestamp_ms, rest zero
    output logic [2:0]  o_m_axis_tuser,   // [2:0] field_tag
    output logic        o_m_axis_tlast    // record_end
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              r_in_last;
    logic              r_out_valid;
    nrsp_pkg::t_result r_out;
    nrsp_pkg::t_result w_result;
    logic              w_fire;

    assign w_fire          = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;

    nrsp_core #(
        .MAX_ALIAS_BYTES (MAX_ALIAS_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.tag;
    assign o_m_axis_tlast  = r_out.rec_end;
    assign o_m_axis_tdata  = {7'd0, r_out.tstamp, r_out.alen, r_out.status,
                              r_out.data, r_out.offset};

    a_mid_record_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.rec_end |-> r_out.status == nrsp_pkg::ST_OK
                                          && r_out.alen == 8'd0
                                          && r_out.tstamp == 64'd0)
        else $error("status fields set on a mid-record byte");

    a_trail_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tag == nrsp_pkg::TAG_TRAIL |-> r_out.offset == 6'd0)
        else $error("trailing byte with non-zero offset");

    a_tstamp_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.tstamp != 64'd0 |-> r_out.status == nrsp_pkg::ST_OK)
        else $error("timestamp reported on a failed record");

    a_fire_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid && r_out.data == $past(r_in_byte)
                   && r_out.rec_end == $past(r_in_last))
        else $error("output register missed a processed byte");

endmodule
